>>> rtl/sgdm_pkg.sv
// Package for the SGD momentum update block: field widths, register codes,
// the item struct and the fixed-point round and saturate helpers.
// No dependencies.
package sgdm_pkg;

  localparam int unsigned ELEMENTS_DEF = 4096;
  localparam int unsigned IDX_W        = 12;
  localparam int unsigned VAL_W        = 32;
  localparam int unsigned COEF_W       = 17;
  localparam int unsigned FRAC_W       = 16;
  localparam int unsigned SAT_BITS     = 32;
  localparam int unsigned CFG_AW       = 4;
  localparam int unsigned IN_TDATA_W   = 80;
  localparam int unsigned OUT_TDATA_W  = 48;

  // coeff * momentum, lr * update, and the widest sum before saturation
  localparam int unsigned PROD1_W = VAL_W + COEF_W + 1;
  localparam int unsigned PROD2_W = 2 * VAL_W;
  localparam int unsigned RND1_W  = PROD1_W - FRAC_W;
  localparam int unsigned RND2_W  = PROD2_W - FRAC_W;
  localparam int unsigned SUM_W   = RND2_W + 1;

  localparam logic signed [SUM_W-1:0] SAT_MAX = (SUM_W'(1) <<< (SAT_BITS - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - SUM_W'(1);

  typedef enum logic [1:0] {
    REG_MAXIMIZE = 2'd0,
    REG_NESTEROV = 2'd1,
    REG_COEFF    = 2'd2,
    REG_LRATE    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             in_range;
    logic [VAL_W:0]   grad;   // signed, one bit wider to hold a negated minimum
    logic [VAL_W-1:0] param;  // signed
  } sgdm_item_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] data;
  } sgdm_wr_t;

  // Drop FRAC_W fraction bits, round to nearest, ties away from zero.
  function automatic logic signed [RND1_W-1:0] round_p1(input logic signed [PROD1_W-1:0] x);
    logic signed [PROD1_W-1:0] t;
    t = x + (PROD1_W'(1) <<< (FRAC_W - 1)) - PROD1_W'(x[PROD1_W-1]);
    return t[PROD1_W-1:FRAC_W];
  endfunction

  function automatic logic signed [RND2_W-1:0] round_p2(input logic signed [PROD2_W-1:0] x);
    logic signed [PROD2_W-1:0] t;
    t = x + (PROD2_W'(1) <<< (FRAC_W - 1)) - PROD2_W'(x[PROD2_W-1]);
    return t[PROD2_W-1:FRAC_W];
  endfunction

  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX;
    end else if (v < SAT_MIN) begin
      r = SAT_MIN;
    end else begin
      r = v;
    end
    return r[VAL_W-1:0];
  endfunction

endpackage

>>> rtl/sgd_momentum_update.sv
// SGD with momentum (optional Nesterov) over a stream of parameter elements.
// Throughput: one item per cycle unless the result stream stalls; an item whose
// index matches one of the two items ahead of momentum write-back waits on the
// memory read-modify-write loop.
// Reset: synchronous, active low; config returns to defaults, then a clearing
// sweep zeroes all DEPTH momentum entries (4096 by default), no items taken.
module sgd_momentum_update import sgdm_pkg::*; #(
  parameter int unsigned ELEMENTS = ELEMENTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [11:0] element_index, [43:12] gradient, [75:44] param_value, [79:76] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [11:0] out_index, [43:12] new_param_value, [47:44] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // configuration
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_AW-1:0]      cfg_paddr,
  input  logic [31:0]            cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  // Entries beyond what a 12-bit index reaches are never addressed.
  localparam int unsigned DEPTH = (ELEMENTS < (2 ** IDX_W)) ? ELEMENTS : (2 ** IDX_W);
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // ---------------- configuration registers ----------------
  logic              maximize_r;
  logic              nesterov_r;
  logic [COEF_W-1:0] coeff_r;
  logic [VAL_W-1:0]  lrate_r;
  logic              cfg_wr;
  cfg_reg_t          cfg_sel;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_sel    = cfg_reg_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      maximize_r <= 1'b0;
      nesterov_r <= 1'b0;
      coeff_r    <= '0;
      lrate_r    <= VAL_W'(66);
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_MAXIMIZE: maximize_r <= cfg_pwdata[0];
        REG_NESTEROV: nesterov_r <= cfg_pwdata[0];
        REG_COEFF:    coeff_r    <= cfg_pwdata[COEF_W-1:0];
        REG_LRATE:    lrate_r    <= cfg_pwdata[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_MAXIMIZE: cfg_prdata = {31'd0, maximize_r};
      REG_NESTEROV: cfg_prdata = {31'd0, nesterov_r};
      REG_COEFF:    cfg_prdata = 32'(coeff_r);
      REG_LRATE:    cfg_prdata = lrate_r;
      default:      cfg_prdata = '0;
    endcase
  end

  // ---------------- input side ----------------
  logic                    adv;       // whole pipeline moves one stage
  logic                    acc;
  logic                    hazard;
  logic                    clr_done;
  logic [IDX_W-1:0]        in_idx;
  logic signed [VAL_W-1:0] in_grad;
  logic signed [VAL_W:0]   grad_ext;
  logic                    in_in_range;
  sgdm_item_t              in_item;

  assign in_idx      = in_tdata[IDX_W-1:0];
  assign in_grad     = in_tdata[IDX_W+VAL_W-1:IDX_W];
  assign grad_ext    = (VAL_W + 1)'(in_grad);
  assign in_in_range = 32'(in_idx) < ELEMENTS;

  // Negate on the way in, one bit wider so the most negative gradient survives.
  assign in_item.idx      = in_idx;
  assign in_item.in_range = in_in_range;
  assign in_item.grad     = maximize_r ? -grad_ext : grad_ext;
  assign in_item.param    = in_tdata[IDX_W+2*VAL_W-1:IDX_W+VAL_W];

  // Hold everything while a result waits; hold new items on a momentum hit.
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv && clr_done && !hazard;
  assign acc       = in_tvalid && in_tready;

  // ---------------- momentum memory ----------------
  logic [VAL_W-1:0] rd_data;
  sgdm_wr_t         mom_wr;

  sgdm_mom_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (acc),
    .rd_addr  (in_idx[AW-1:0]),
    .rd_data  (rd_data),
    .wr_en    (mom_wr.en),
    .wr_addr  (mom_wr.idx[AW-1:0]),
    .wr_data  (mom_wr.data),
    .clr_done (clr_done)
  );

  // ---------------- pipeline ----------------
  logic             s3_vld, s5_vld;
  sgdm_item_t       s3_item, s5_item;
  logic [VAL_W-1:0] s3_mom, s5_upd;
  logic [IDX_W-1:0] res_idx;
  logic [VAL_W-1:0] res_val;

  sgdm_mom_calc u_mom (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (acc),
    .in_item  (in_item),
    .rd_data  (rd_data),
    .coeff    (coeff_r),
    .chk_idx  (in_idx),
    .hazard   (hazard),
    .wr       (mom_wr),
    .out_vld  (s3_vld),
    .out_item (s3_item),
    .out_mom  (s3_mom)
  );

  sgdm_lookahead u_look (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .coeff    (coeff_r),
    .nesterov (nesterov_r),
    .in_vld   (s3_vld),
    .in_item  (s3_item),
    .in_mom   (s3_mom),
    .out_vld  (s5_vld),
    .out_item (s5_item),
    .out_upd  (s5_upd)
  );

  sgdm_apply u_apply (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .lrate   (lrate_r),
    .in_vld  (s5_vld),
    .in_item (s5_item),
    .in_upd  (s5_upd),
    .out_vld (out_tvalid),
    .out_idx (res_idx),
    .out_val (res_val)
  );

  assign out_tdata = {(OUT_TDATA_W - IDX_W - VAL_W)'(0), res_val, res_idx};

  // ---------------- assertions ----------------
  // A read never takes an entry that is being written in the same cycle.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_in_range && mom_wr.en |-> in_idx != mom_wr.idx)
    else $error("momentum read collides with write-back");

  // No result appears before the clearing sweep has finished.
  a_no_out_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !clr_done |-> !out_tvalid)
    else $error("result during momentum clear");

  // A stalled result blocks new items.
  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("item accepted while pipeline is stalled");

endmodule

>>> rtl/sgdm_mom_store.sv
// Momentum memory: one write and one registered read per cycle, plus the
// clearing sweep after reset. Depends on sgdm_pkg.
module sgdm_mom_store import sgdm_pkg::*; #(
  parameter int unsigned DEPTH = ELEMENTS_DEF,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [VAL_W-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [VAL_W-1:0] wr_data,
  output logic             clr_done
);

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rd_data_r;
  logic [AW-1:0]    clr_cnt_r;
  logic             clr_done_r;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [VAL_W-1:0] wdata;

  // sweep zeros through every entry before the first item
  assign we    = !clr_done_r || wr_en;
  assign waddr = clr_done_r ? wr_addr : clr_cnt_r;
  assign wdata = clr_done_r ? wr_data : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clr_done_r <= 1'b0;
    end else if (!clr_done_r) begin
      if (clr_cnt_r == AW'(DEPTH - 1)) begin
        clr_done_r <= 1'b1;
      end else begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clr_done = clr_done_r;

endmodule

>>> rtl/sgdm_mom_calc.sv
// Momentum recurrence stages: coeff * m, then round, add gradient, saturate
// and write back. Flags new items that hit an entry still in flight.
// Depends on sgdm_pkg.
module sgdm_mom_calc import sgdm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_vld,
  input  sgdm_item_t        in_item,
  input  logic [VAL_W-1:0]  rd_data,
  input  logic [COEF_W-1:0] coeff,
  input  logic [IDX_W-1:0]  chk_idx,
  output logic              hazard,
  output sgdm_wr_t          wr,
  output logic              out_vld,
  output sgdm_item_t        out_item,
  output logic [VAL_W-1:0]  out_mom
);

  logic                      s1_vld_r, s2_vld_r, s3_vld_r;
  sgdm_item_t                s1_item_r, s2_item_r, s3_item_r;
  logic signed [PROD1_W-1:0] s2_prod_r, s2_prod_nxt;
  logic [VAL_W-1:0]          s3_mom_r;
  logic signed [VAL_W-1:0]   s3_mom_nxt;
  logic signed [COEF_W:0]    coef_s;
  logic signed [VAL_W-1:0]   mom_rd;
  logic signed [VAL_W:0]     s2_grad;
  logic signed [RND1_W-1:0]  s2_rnd;
  logic signed [SUM_W-1:0]   s2_sum;

  assign coef_s      = {1'b0, coeff};
  assign mom_rd      = s1_item_r.in_range ? rd_data : '0;
  assign s2_prod_nxt = coef_s * mom_rd;

  assign s2_grad    = s2_item_r.grad;
  assign s2_rnd     = round_p1(s2_prod_r);
  assign s2_sum     = SUM_W'(s2_rnd) + SUM_W'(s2_grad);
  assign s3_mom_nxt = sat_val(s2_sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item_r <= in_item;
      s2_item_r <= s1_item_r;
      s2_prod_r <= s2_prod_nxt;
      s3_item_r <= s2_item_r;
      s3_mom_r  <= s3_mom_nxt;
    end
  end

  // write back as the new momentum leaves stage two
  assign wr.en   = adv && s2_vld_r && s2_item_r.in_range;
  assign wr.idx  = s2_item_r.idx;
  assign wr.data = s3_mom_nxt;

  assign hazard = (s1_vld_r && (s1_item_r.idx == chk_idx)) ||
                  (s2_vld_r && (s2_item_r.idx == chk_idx));

  assign out_vld  = s3_vld_r;
  assign out_item = s3_item_r;
  assign out_mom  = s3_mom_r;

endmodule

>>> rtl/sgdm_lookahead.sv
// Update select: plain momentum, or the Nesterov form coeff * m + g.
// Two register stages. Depends on sgdm_pkg.
module sgdm_lookahead import sgdm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic [COEF_W-1:0] coeff,
  input  logic              nesterov,
  input  logic              in_vld,
  input  sgdm_item_t        in_item,
  input  logic [VAL_W-1:0]  in_mom,
  output logic              out_vld,
  output sgdm_item_t        out_item,
  output logic [VAL_W-1:0]  out_upd
);

  logic                      s4_vld_r, s5_vld_r;
  sgdm_item_t                s4_item_r, s5_item_r;
  logic signed [PROD1_W-1:0] s4_prod_r, s4_prod_nxt;
  logic [VAL_W-1:0]          s4_mom_r;
  logic [VAL_W-1:0]          s5_upd_r, s5_upd_nxt;
  logic signed [COEF_W:0]    coef_s;
  logic signed [VAL_W-1:0]   mom_s;
  logic signed [VAL_W:0]     s4_grad;
  logic signed [RND1_W-1:0]  s4_rnd;
  logic signed [SUM_W-1:0]   s4_sum;

  assign coef_s      = {1'b0, coeff};
  assign mom_s       = in_mom;
  assign s4_prod_nxt = coef_s * mom_s;

  assign s4_grad    = s4_item_r.grad;
  assign s4_rnd     = round_p1(s4_prod_r);
  assign s4_sum     = SUM_W'(s4_rnd) + SUM_W'(s4_grad);
  assign s5_upd_nxt = nesterov ? sat_val(s4_sum) : s4_mom_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
    end else if (adv) begin
      s4_vld_r <= in_vld;
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_item_r <= in_item;
      s4_prod_r <= s4_prod_nxt;
      s4_mom_r  <= in_mom;
      s5_item_r <= s4_item_r;
      s5_upd_r  <= s5_upd_nxt;
    end
  end

  assign out_vld  = s5_vld_r;
  assign out_item = s5_item_r;
  assign out_upd  = s5_upd_r;

endmodule

>>> rtl/sgdm_apply.sv
// Apply stages: learning_rate * update, then round, add to the parameter,
// saturate into the output register. Depends on sgdm_pkg.
module sgdm_apply import sgdm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic [VAL_W-1:0] lrate,
  input  logic             in_vld,
  input  sgdm_item_t       in_item,
  input  logic [VAL_W-1:0] in_upd,
  output logic             out_vld,
  output logic [IDX_W-1:0] out_idx,
  output logic [VAL_W-1:0] out_val
);

  logic                      s6_vld_r, o_vld_r;
  sgdm_item_t                s6_item_r;
  logic signed [PROD2_W-1:0] s6_prod_r, s6_prod_nxt;
  logic [IDX_W-1:0]          o_idx_r;
  logic [VAL_W-1:0]          o_val_r, o_val_nxt;
  logic signed [VAL_W-1:0]   lr_s, upd_s, s6_param;
  logic signed [RND2_W-1:0]  s6_rnd;
  logic signed [SUM_W-1:0]   s6_sum;

  assign lr_s        = lrate;
  assign upd_s       = in_upd;
  assign s6_prod_nxt = lr_s * upd_s;

  assign s6_param  = s6_item_r.param;
  assign s6_rnd    = round_p2(s6_prod_r);
  assign s6_sum    = SUM_W'(s6_param) + SUM_W'(s6_rnd);
  assign o_val_nxt = sat_val(s6_sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
      o_vld_r  <= 1'b0;
    end else if (adv) begin
      s6_vld_r <= in_vld;
      o_vld_r  <= s6_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_item_r <= in_item;
      s6_prod_r <= s6_prod_nxt;
      o_idx_r   <= s6_item_r.idx;
      o_val_r   <= o_val_nxt;
    end
  end

  assign out_vld = o_vld_r;
  assign out_idx = o_idx_r;
  assign out_val = o_val_r;

endmodule

>>> tb/tb.sv
// Self-checking testbench for sgd_momentum_update: drives update items over the
// input stream and APB writes, predicts every result. Depends on sgdm_pkg and sgd_momentum_update.
`timescale 1ns / 1ps

module tb import sgdm_pkg::*;;

  localparam int     LATENCY  = 6;
  localparam longint Q_MAX    = 64'sd2147483647;
  localparam longint Q_MIN    = -64'sd2147483648;
  localparam logic [31:0] V_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] V_MIN = 32'h8000_0000;
  localparam int     PHASES   = 8;
  localparam int     PHASE_LEN = 204;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] value;
  } param_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // [11:0] element_index, [43:12] gradient, [75:44] param_value, [79:76] zero
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [11:0] out_index, [43:12] new_param_value, [47:44] zero
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]      cfg_paddr = '0;
  logic [31:0]            cfg_pwdata = '0;
  logic [31:0]            cfg_prdata;
  logic                   cfg_pready;

  // Predictor state: register mirrors and the momentum memory copy.
  logic                    maximize_q = 1'b0;
  logic                    nesterov_q = 1'b0;
  logic [COEF_W-1:0]       coeff_q    = '0;
  logic signed [VAL_W-1:0] lrate_q    = 32'sd66;
  logic signed [VAL_W-1:0] momentum_q [ELEMENTS_DEF];

  param_result_t pending_params[$];
  bit            steady = 1'b0;   // when set, neither side idles
  int            fail_count = 0;
  int            items_sent = 0;
  int            results_seen = 0;
  int            cfg_writes = 0;

  sgd_momentum_update i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Drop 16 fraction bits, round to nearest, ties away from zero.
  function automatic longint round_q16(longint x);
    longint mag;
    longint r;
    mag = (x < 0) ? -x : x;
    r = (mag + 64'sd32768) >>> 16;
    return (x < 0) ? -r : r;
  endfunction

  function automatic longint clamp_q16(longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  // Advance the element's momentum and return its updated parameter value.
  function automatic logic [VAL_W-1:0] next_param_value(logic [IDX_W-1:0] idx,
                                                        logic signed [VAL_W-1:0] grad,
                                                        logic signed [VAL_W-1:0] param);
    longint g;
    longint m;
    longint u;
    longint np;
    g = longint'(grad);
    if (maximize_q) g = -g;   // negated minimum stays exact in 64 bits
    m = clamp_q16(round_q16(longint'(coeff_q) * longint'(momentum_q[idx])) + g);
    momentum_q[idx] = m[VAL_W-1:0];
    u = nesterov_q ? clamp_q16(round_q16(longint'(coeff_q) * m) + g) : m;
    np = clamp_q16(longint'(param) + round_q16(longint'(lrate_q) * u));
    return np[VAL_W-1:0];
  endfunction

  // APB write: setup cycle, access cycle held until pready, then the bus returns to idle.
  task automatic write_reg(cfg_reg_t r, logic [31:0] v);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= CFG_AW'({r, 2'b00});
    cfg_pwdata  <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (r)
      REG_MAXIMIZE: maximize_q = v[0];
      REG_NESTEROV: nesterov_q = v[0];
      REG_COEFF:    coeff_q    = v[COEF_W-1:0];
      REG_LRATE:    lrate_q    = v;
      default: ;
    endcase
    cfg_writes++;
    @(posedge clk);
  endtask

  task automatic set_config(logic maxi, logic nest, logic [31:0] coeff, logic [31:0] lr);
    write_reg(REG_MAXIMIZE, {31'd0, maxi});
    write_reg(REG_NESTEROV, {31'd0, nest});
    write_reg(REG_COEFF, coeff);
    write_reg(REG_LRATE, lr);
  endtask

  // Send one item after a random gap; valid stays high when the next gap is zero.
  task automatic send_update(logic [IDX_W-1:0] idx, logic [VAL_W-1:0] grad,
                             logic [VAL_W-1:0] param);
    int gap;
    param_result_t exp_r;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'd0, param, grad, idx};
    do @(posedge clk); while (in_tready !== 1'b1);
    exp_r.idx   = idx;
    exp_r.value = next_param_value(idx, grad, param);
    pending_params.push_back(exp_r);
    items_sent++;
  endtask

  // Hold the input idle until every predicted result has come back.
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    while (pending_params.size() != 0) @(posedge clk);
  endtask

  // Result sink: random stalls per result, compare with the oldest prediction.
  initial begin : check_results
    int stall;
    param_result_t exp_r;
    forever begin
      stall = steady ? 0 : $urandom_range(0, 6);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      results_seen++;
      if (pending_params.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("ERROR: result with nothing expected: index %0d value %h",
                   out_tdata[11:0], out_tdata[43:12]);
      end else begin
        exp_r = pending_params.pop_front();
        if (out_tdata[11:0] !== exp_r.idx || out_tdata[43:12] !== exp_r.value) begin
          fail_count++;
          if (fail_count <= 10)
            $display("ERROR: expected index %0d value %h, got index %0d value %h",
                     exp_r.idx, exp_r.value, out_tdata[11:0], out_tdata[43:12]);
        end
      end
    end
  end

  // Reset values: coefficient zero, rate 66, momentum all zero.
  task automatic test_reset_defaults();
    send_update(12'd0, V_MAX, V_MAX);
    send_update(12'd4095, V_MIN, V_MIN);
    send_update(12'd0, 32'd0, 32'd0);
    send_update(12'd2048, 32'd1, 32'hFFFF_FFFF);
    wait_results_drained();
  endtask

  // Coefficient one, rate minus one; back-to-back hits on one index exercise
  // the read-modify-write stall, and a repeated max gradient saturates momentum.
  task automatic test_plain_momentum();
    set_config(1'b0, 1'b0, 32'd65536, 32'hFFFF_0000);
    steady = 1'b1;
    send_update(12'd5, 32'h0001_0000, 32'd0);
    send_update(12'd5, 32'h0001_0000, 32'd0);
    send_update(12'd5, 32'h0001_0000, 32'd0);
    send_update(12'd6, V_MAX, 32'd0);
    send_update(12'd6, V_MAX, V_MIN);
    send_update(12'd5, 32'hFFFF_8000, 32'h0000_4000);
    steady = 1'b0;
    wait_results_drained();
  endtask

  // Maximize with Nesterov, coefficient above one, maximum rate; negate the
  // most negative gradient.
  task automatic test_nesterov_maximize();
    set_config(1'b1, 1'b1, 32'd131071, V_MAX);
    send_update(12'd7, V_MIN, 32'd0);
    send_update(12'd7, V_MIN, V_MIN);
    send_update(12'd8, V_MAX, V_MAX);
    send_update(12'd8, 32'h0000_8000, 32'd0);
    send_update(12'd4095, 32'hFFFF_FFFF, 32'd1);
    wait_results_drained();
  endtask

  // Most negative rate, then a zero rate that leaves the value untouched.
  task automatic test_rate_extremes();
    set_config(1'b0, 1'b1, 32'h0000_8000, V_MIN);
    send_update(12'd9, V_MAX, V_MAX);
    send_update(12'd9, V_MIN, V_MIN);
    send_update(12'd10, 32'd1, 32'd0);
    wait_results_drained();
    write_reg(REG_LRATE, 32'd0);
    send_update(12'd9, V_MAX, 32'd123);
    wait_results_drained();
  endtask

  function automatic logic [VAL_W-1:0] rand_q16();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return V_MAX;
          1: return V_MIN;
          2: return 32'd0;
          3: return 32'hFFFF_FFFF;
          default: return 32'd1;
        endcase
      end
      1, 2, 3, 4: return 32'($urandom_range(0, 524288)) - 32'd262144;  // within +-4.0
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] rand_index();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return IDX_W'($urandom_range(0, 7));  // hot set, hazards
      6: return $urandom_range(0, 1) ? 12'd4095 : 12'd0;
      default: return IDX_W'($urandom);
    endcase
  endfunction

  // Random phases: fresh settings per phase, mostly hot indices with
  // accumulating momentum, bursts without idling, one full drain mid-phase.
  task automatic test_random_updates();
    logic [31:0] coeff;
    logic [31:0] lr;
    for (int ph = 0; ph < PHASES; ph++) begin
      case ($urandom_range(0, 4))
        0: coeff = 32'd0;
        1: coeff = 32'd65536;
        2: coeff = 32'd131071;
        3: coeff = $urandom_range(0, 65536);
        default: coeff = $urandom_range(49152, 65536);
      endcase
      case ($urandom_range(0, 5))
        0: lr = V_MIN;
        1: lr = V_MAX;
        2: lr = 32'd0;
        default: lr = 32'($urandom_range(0, 131072)) - 32'd65536;
      endcase
      set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), coeff, lr);
      steady = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_LEN; n++) begin
        if ($urandom_range(0, 39) == 0) steady = !steady;
        if (ph == 2 && n == PHASE_LEN / 2) wait_results_drained();
        send_update(rand_index(), rand_q16(), rand_q16());
      end
      steady = 1'b0;
      wait_results_drained();
    end
  endtask

  initial begin : run_tests
    foreach (momentum_q[i]) momentum_q[i] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_plain_momentum();
    test_nesterov_maximize();
    test_rate_extremes();
    test_random_updates();
    wait_results_drained();
    repeat (4 * LATENCY) @(posedge clk);
    if (pending_params.size() != 0) begin
      fail_count++;
      $display("ERROR: %0d results never arrived", pending_params.size());
    end
    $display("Covered %0d updates (%0d results) over %0d register writes,", items_sent,
             results_seen, cfg_writes);
    $display("plain and Nesterov modes, maximize, coefficient and rate extremes.");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run, clearing sweep included.
  initial begin : watchdog
    #2ms;
    $display("tb: failure");
    $finish;
  end

endmodule
